>>> hw/rtl/keyword_substitution_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// keyword substitution cipher assertion macros
// concurrent check wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("keyword cipher check failed");
`define KSC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("keyword cipher check failed");
`else
`define KSC_ASSERT(label, prop)
`define KSC_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hw/rtl/kscip_pkg.sv
// ----------------------------------------------------------------------------
// kscip_pkg
// shared types and character constants of the keyword substitution cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kscip_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned LetterW    = 5;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_KEY   = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5A;
  localparam logic [7:0] ChLoA = 8'h61;
  localparam logic [7:0] ChLoZ = 8'h7A;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_KEY   = 2'd1,
    OP_TEXT  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic               letter;
    logic               lower;
    logic [LetterW-1:0] idx;
    logic [7:0]         raw;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  typedef struct packed {
    logic pop;
    logic fill_active;
    logic table_complete;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/keyword_substitution_cipher_core.sv
// with a complete table, an input reaches the output via the queue entry and output register
// throughput: one item per cycle unless the queue is full, the output stalls or the walk runs;
// start and key items give no output transfer; the first text item after a start or reset
// waits for the completion walk, which fills the table stepping one letter per cycle
// reset: asynchronous active low, clears key state, queue and decrypt mode; tables are unset
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core
// keyword monoalphabetic substitution cipher with queued front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyword_substitution_cipher_core_defines.svh"
module keyword_substitution_cipher_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] in_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] out_byte_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);

  kscip_pkg::head_t   head;
  kscip_pkg::status_t status;
  logic               decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      decrypt_q <= cfg_wdata_i;
    end
  end

  kscip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .in_byte_i  (in_byte_i),
    .status_i   (status),
    .head_o     (head)
  );

  kscip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decrypt_i   (decrypt_q),
    .head_i      (head),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

  `KSC_ASSERT(a_no_pop_in_walk, status.fill_active |-> !status.pop)
  `KSC_ASSERT(a_pop_needs_head, status.pop |-> head.valid)
  `KSC_ASSERT(a_walk_ends_complete, $fell(status.fill_active) |-> status.table_complete)
  `KSC_ASSERT(a_out_from_pop, $rose(out_valid_o) |-> $past(status.pop))

endmodule
`default_nettype wire

>>> hw/rtl/kscip_front.sv
// ----------------------------------------------------------------------------
// kscip_front
// takes input transfers, classifies them and queues the resulting operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kscip_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output                     logic in_stall_o,
  input  wire                logic [1:0] req_type_i,
  input  wire                logic [7:0] in_byte_i,
  input  wire kscip_pkg::status_t status_i,
  output kscip_pkg::head_t   head_o
);

  localparam logic [1:0] QDepth = 2'd2;

  kscip_pkg::op_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  kscip_pkg::op_t op;
  logic           keep;
  logic           is_upper, is_lower;
  logic           push, pop;

  always_comb begin
    is_upper    = (in_byte_i >= kscip_pkg::ChUpA) && (in_byte_i <= kscip_pkg::ChUpZ);
    is_lower    = (in_byte_i >= kscip_pkg::ChLoA) && (in_byte_i <= kscip_pkg::ChLoZ);
    op.letter   = is_upper || is_lower;
    op.lower    = is_lower;
    op.idx      = is_lower ? kscip_pkg::LetterW'(in_byte_i - kscip_pkg::ChLoA)
                           : kscip_pkg::LetterW'(in_byte_i - kscip_pkg::ChUpA);
    op.raw      = in_byte_i;
    op.kind     = kscip_pkg::OP_START;
    keep        = 1'b0;
    unique case (req_type_i)
      kscip_pkg::REQ_START: begin
        op.kind = kscip_pkg::OP_START;
        keep    = 1'b1;
      end
      kscip_pkg::REQ_KEY: begin
        // non-letter key bytes have no effect
        op.kind = kscip_pkg::OP_KEY;
        keep    = op.letter;
      end
      kscip_pkg::REQ_TEXT: begin
        op.kind = kscip_pkg::OP_TEXT;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (count_q == QDepth);
  assign push       = in_valid_i && !in_stall_o && keep;
  assign pop        = status_i.pop;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.op    = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> hw/rtl/kscip_back.sv
// ----------------------------------------------------------------------------
// kscip_back
// carries out queued operations: key build, table completion walk, lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kscip_back (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic decrypt_i,
  input  wire kscip_pkg::head_t head_i,
  output kscip_pkg::status_t status_o,
  output                     logic out_valid_o,
  input  wire                logic out_stall_i,
  output                     logic [7:0] out_byte_o
);

  localparam int unsigned W = kscip_pkg::LetterW;
  localparam int unsigned N = kscip_pkg::NumLetters;

  logic [W-1:0] fwd_q [N];
  logic [W-1:0] inv_q [N];

  logic [N-1:0] used_q, used_d;
  logic [W-1:0] fill_q, fill_d;
  logic         complete_q, complete_d;
  logic         walk_q, walk_d;
  logic [W-1:0] k_q, k_d;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_byte_q, out_byte_d;

  logic         place_en, can_place;
  logic [W-1:0] place_idx;
  logic         pop;
  logic         slot_free;
  logic [W-1:0] sub;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign sub       = decrypt_i ? inv_q[head_i.op.idx] : fwd_q[head_i.op.idx];
  assign can_place = place_en && !used_q[place_idx] && (fill_q < W'(N));

  always_comb begin
    place_en    = 1'b0;
    place_idx   = head_i.op.idx;
    pop         = 1'b0;
    used_d      = used_q;
    fill_d      = fill_q;
    complete_d  = complete_q;
    walk_d      = walk_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    if (walk_q) begin
      // fill the rest of the table from z down to a
      place_en  = 1'b1;
      place_idx = k_q;
      if (k_q == '0) begin
        walk_d     = 1'b0;
        complete_d = 1'b1;
      end else begin
        k_d = k_q - 1'b1;
      end
    end else if (head_i.valid) begin
      unique case (head_i.op.kind)
        kscip_pkg::OP_START: begin
          pop        = 1'b1;
          used_d     = '0;
          fill_d     = '0;
          complete_d = 1'b0;
        end
        kscip_pkg::OP_KEY: begin
          pop      = 1'b1;
          place_en = !complete_q;
        end
        kscip_pkg::OP_TEXT: begin
          if (!complete_q) begin
            walk_d = 1'b1;
            k_d    = W'(N - 1);
          end else if (slot_free) begin
            pop         = 1'b1;
            out_valid_d = 1'b1;
            if (head_i.op.letter) begin
              out_byte_d = (head_i.op.lower ? kscip_pkg::ChLoA : kscip_pkg::ChUpA)
                           + {3'b000, sub};
            end else begin
              out_byte_d = head_i.op.raw;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    if (can_place) begin
      used_d[place_idx] = 1'b1;
      fill_d            = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_place) begin
      fwd_q[fill_q]    <= place_idx;
      inv_q[place_idx] <= fill_q;
    end
    out_byte_q <= out_byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      fill_q      <= '0;
      complete_q  <= 1'b0;
      walk_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      fill_q      <= fill_d;
      complete_q  <= complete_d;
      walk_q      <= walk_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.pop            = pop;
  assign status_o.fill_active    = walk_q;
  assign status_o.table_complete = complete_q;
  assign out_valid_o             = out_valid_q;
  assign out_byte_o              = out_byte_q;

endmodule
`default_nettype wire
